// ===== hw/rtl/schash_pkg.sv =====
// Shared types, constants and status codes of the sorted chain hash table.
`default_nettype none
package schash_pkg;

  localparam int unsigned MaxBucketsDef = 256;
  localparam int unsigned PoolNodesDef  = 1024;
  localparam int unsigned KeyW  = 64;
  localparam int unsigned DataW = 64;
  localparam int unsigned CfgW  = 9;
  localparam int unsigned StW   = 3;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_REMOVE = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic              op;
    logic [KeyW-1:0]   req_id;
    logic [DataW-1:0]  payload;
  } schash_in_t;

  typedef struct packed {
    logic [StW-1:0]    status;
    logic [DataW-1:0]  payload_out;
  } schash_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture request, start modulo
    logic mod_step;  // one modulo iteration
    logic head_rd;   // read bucket head
    logic node_rd;   // read node at cursor
    logic advance;   // prev <= cur, cur <= link
    logic pop;       // read free stack top
    logic ins_wr;    // write new node and link it
    logic rem_wr;    // unlink cursor and push it
    logic res_ld;    // load result register
    logic [StW-1:0] res_status;
  } schash_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic mod_done;
    logic cur_nil;
    logic key_eq;
    logic key_gt;
    logic walk_limit;
    logic pool_empty;
    logic pop_bad;
    logic op;
  } schash_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/schash_dp.sv =====
// Datapath of the hash table: modulo unit, bucket heads, node pool, free stack.
`default_nettype none
module schash_dp import schash_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = MaxBucketsDef,
  parameter int unsigned POOL_NODES  = PoolNodesDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire schash_in_t    req,
  input  wire logic          cfg_we,
  input  wire logic [CfgW-1:0] cfg_data,
  input  wire schash_cmd_t   cmd,
  output schash_sts_t        sts,
  output schash_out_t        res
);

  localparam int unsigned BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NW  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned LW  = NW + 1;        // link with null marker
  localparam int unsigned CW  = $clog2(POOL_NODES + 1);
  localparam int unsigned MW  = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned RW  = (MW > CfgW) ? MW : CfgW;
  localparam logic [LW-1:0] NIL = LW'(POOL_NODES);
  localparam logic [RW-1:0] MAXB = RW'(MAX_BUCKETS);
  localparam int unsigned KCW = $clog2(KeyW + 1);

  // Bucket count register.
  logic [RW-1:0] bcnt_r;
  logic [RW-1:0] cfg_v;
  always_comb begin
    cfg_v = RW'(cfg_data);
    if (cfg_v == '0) cfg_v = RW'(1);
    if (cfg_v > MAXB) cfg_v = MAXB;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) bcnt_r <= (MAXB < RW'(256)) ? MAXB : RW'(256);
    else if (cfg_we) bcnt_r <= cfg_v;
  end

  // Request capture and restoring modulo, one key bit per cycle.
  schash_in_t   req_r;
  logic [RW:0]  rem_r;
  logic [KCW-1:0] mcnt_r;
  logic [RW:0]  rem_sh;
  logic         mod_done_r;
  always_comb rem_sh = {rem_r[RW-1:0], req_r.req_id[mcnt_r[$clog2(KeyW)-1:0]]};
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req;
      rem_r  <= '0;
      mcnt_r <= KCW'(KeyW - 1);
    end else if (cmd.mod_step) begin
      rem_r  <= (rem_sh >= {1'b0, bcnt_r}) ? rem_sh - {1'b0, bcnt_r} : rem_sh;
      mcnt_r <= mcnt_r - KCW'(1);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) mod_done_r <= 1'b0;
    else if (cmd.load) mod_done_r <= 1'b0;
    else if (cmd.mod_step && mcnt_r == '0) mod_done_r <= 1'b1;
  end
  logic [BW-1:0] bkt;
  always_comb begin
    if (rem_r >= (RW+1)'(MAX_BUCKETS)) bkt = BW'(MAX_BUCKETS - 1);
    else bkt = rem_r[BW-1:0];
  end

  // Bucket heads: memory plus valid bits, invalid reads as null.
  logic [LW-1:0] heads_mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] hvld_r;
  logic [LW-1:0] head_q;
  logic          head_v;

  // Node pool memories.
  logic [KeyW-1:0]  keys_mem [POOL_NODES];
  logic [DataW-1:0] pay_mem  [POOL_NODES];
  logic [LW-1:0]    link_mem [POOL_NODES];
  logic [KeyW-1:0]  key_q;
  logic [DataW-1:0] pay_q;
  logic [LW-1:0]    link_q;

  // Free stack: slots below the lowest fill count ever reached were never
  // written and still stand for their reset content POOL_NODES-1-i.
  logic [NW-1:0]    fs_mem [POOL_NODES];
  logic [CW-1:0]    fcnt_r;
  logic [CW-1:0]    lowm_r;
  logic [NW-1:0]    fs_q;
  logic [NW-1:0]    fs_addr;

  logic [LW-1:0] cur_r, prev_r;
  logic [CW-1:0] steps_r;
  logic [LW-1:0] cur_next;
  logic [NW-1:0] pop_val;

  assign cur_next = (link_q < NIL) ? link_q : NIL;
  assign fs_addr  = NW'(fcnt_r - CW'(1));
  assign pop_val  = (CW'(fs_addr) >= lowm_r) ? fs_q : NW'(POOL_NODES - 1) - fs_addr;

  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      head_q <= heads_mem[bkt];
      head_v <= hvld_r[bkt];
    end
    if (cmd.node_rd) begin
      key_q  <= keys_mem[cur_r[NW-1:0]];
      pay_q  <= pay_mem[cur_r[NW-1:0]];
      link_q <= link_mem[cur_r[NW-1:0]];
    end
    if (cmd.pop) fs_q <= fs_mem[fs_addr];
    if (cmd.ins_wr) begin
      keys_mem[pop_val] <= req_r.req_id;
      pay_mem[pop_val]  <= req_r.payload;
      link_mem[pop_val] <= cur_r;
    end
    if (cmd.ins_wr && prev_r != NIL) link_mem[prev_r[NW-1:0]] <= LW'(pop_val);
    if (cmd.rem_wr && prev_r != NIL) link_mem[prev_r[NW-1:0]] <= cur_next;
    if (cmd.ins_wr && prev_r == NIL) heads_mem[bkt] <= LW'(pop_val);
    if (cmd.rem_wr && prev_r == NIL) heads_mem[bkt] <= cur_next;
    if (cmd.rem_wr && fcnt_r < CW'(POOL_NODES)) fs_mem[fcnt_r[NW-1:0]] <= cur_r[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvld_r <= '0;
      fcnt_r <= CW'(POOL_NODES);
      lowm_r <= CW'(POOL_NODES);
    end else begin
      if ((cmd.ins_wr || cmd.rem_wr) && prev_r == NIL) hvld_r[bkt] <= 1'b1;
      if (cmd.ins_wr) begin
        fcnt_r <= fcnt_r - CW'(1);
        if (CW'(fs_addr) < lowm_r) lowm_r <= CW'(fs_addr);
      end
      if (cmd.rem_wr && fcnt_r < CW'(POOL_NODES)) fcnt_r <= fcnt_r + CW'(1);
    end
  end

  // Walk cursor.
  logic [LW-1:0] head_eff;
  always_comb begin
    head_eff = head_v ? head_q : NIL;
    if (head_eff >= NIL) head_eff = NIL;
  end

  // Head latch: head_pend_r marks a head read, and the cursor then loads the registered head value.
  logic head_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) head_pend_r <= 1'b0;
    else head_pend_r <= cmd.head_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_r  <= NIL;
      steps_r <= '0;
    end
    if (head_pend_r) cur_r <= head_eff;
    if (cmd.advance) begin
      prev_r  <= cur_r;
      cur_r   <= cur_next;
      steps_r <= steps_r + CW'(1);
    end
  end

  logic [LW-1:0] cur_view;
  assign cur_view = head_pend_r ? head_eff : cur_r;

  always_comb begin
    sts.mod_done   = mod_done_r;
    sts.cur_nil    = (cur_view == NIL);
    sts.key_eq     = (key_q == req_r.req_id);
    sts.key_gt     = (key_q > req_r.req_id);
    sts.walk_limit = (steps_r >= CW'(POOL_NODES));
    sts.pool_empty = (fcnt_r == '0) || (fcnt_r > CW'(POOL_NODES));
    sts.pop_bad    = (CW'(pop_val) >= CW'(POOL_NODES));
    sts.op         = req_r.op;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res.status      <= cmd.res_status;
      res.payload_out <= (cmd.res_status == ST_EXISTS || cmd.res_status == ST_REMOVED)
                         ? pay_q : '0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/schash_ctrl.sv =====
// Controller state machine of the hash table.
`default_nettype none
module schash_ctrl import schash_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire schash_sts_t sts,
  output schash_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_HEAD  = 4'd2;
  localparam logic [3:0] S_HWAIT = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_NRD   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_POP   = 4'd7;
  localparam logic [3:0] S_PWAIT = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.head_rd = 1'b1;
          state_nxt   = S_HWAIT;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_HEAD:  state_nxt = S_HWAIT;
      S_HWAIT: state_nxt = S_CHK;
      S_CHK: begin
        if (sts.cur_nil || sts.walk_limit) begin
          state_nxt = S_DONE;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_NRD: state_nxt = S_CMP;
      S_CMP: begin
        if (sts.key_eq) begin
          cmd.res_ld = 1'b1;
          if (sts.op == OP_INSERT) begin
            cmd.res_status = ST_EXISTS;
          end else begin
            cmd.res_status = ST_REMOVED;
            cmd.rem_wr     = 1'b1;
          end
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.key_gt) begin
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_DONE: begin
        // Not found: insert needs a free node, remove reports a miss.
        if (sts.op == OP_REMOVE) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          ov_nxt         = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.pool_empty) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_FULL;
          ov_nxt         = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_PWAIT;
        end
      end
      S_POP: state_nxt = S_PWAIT;
      S_PWAIT: begin
        cmd.res_ld = 1'b1;
        if (sts.pop_bad) begin
          cmd.res_status = ST_FULL;
        end else begin
          cmd.res_status = ST_INSERTED;
          cmd.ins_wr     = 1'b1;
        end
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_chain_hash_table.sv =====
// Top level of the sorted chain hash table.
// Usage:
//   in_valid/in_ready carry one request: op (insert or remove), req_id,
//   payload. out_valid/out_ready return one result per request: status and
//   payload_out. cfg_valid/cfg_ready write bucket_count; write it only while
//   the block is idle. cfg_ready is always high.
// Sequence: a bit-serial modulo of the 64-bit id, then the bucket head
//   read, then a read and compare of each chain node in turn; a larger key
//   or the end of the chain ends the walk, and an insert then pops a free
//   node. out_valid rises once the result register is loaded.
// Flow: one request at a time; the next is taken in the cycle the
//   result leaves. The shift-subtract modulo unit and the single read
//   port of the node memory set the time that each request takes.
// Reset: synchronous, active low; all buckets empty, every node free,
//   bucket_count min(MAX_BUCKETS, 256). No clearing pass is needed.
// Stall: a result waits in the output register while out_ready is low; the
//   next request is taken once the result has been taken or is leaving.
`default_nettype none
module sorted_chain_hash_table import schash_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = MaxBucketsDef,
  parameter int unsigned POOL_NODES  = PoolNodesDef
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire schash_in_t      in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output schash_out_t          out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [CfgW-1:0] cfg_data
);

  schash_cmd_t cmd;
  schash_sts_t sts;

  assign cfg_ready = 1'b1;

  schash_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  schash_dp #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .req(in_data),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .res(out_data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/schash_chk.sv =====
// Port-level checker for the hash table, bound to the top level.
`default_nettype none
module schash_chk import schash_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire schash_out_t out_data
);

  // Output status and payload hold while stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // No new request taken right after acceptance.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // When a request is taken as the previous result leaves, out_valid is low in the cycle after.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid || !$past(out_valid) || $past(out_ready) == 1'b0)
    else $error("result too early");

  // Status codes stay in range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_FULL)
    else $error("bad status");

  // Payload is zero unless exists or removed.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_INSERTED || out_data.status == ST_NOT_FOUND ||
                  out_data.status == ST_FULL) |-> out_data.payload_out == '0)
    else $error("nonzero payload");

endmodule

bind sorted_chain_hash_table schash_chk u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
`default_nettype wire

// ===== tb/sorted_chain_hash_table_test.sv =====
// Self-checking testbench for the sorted chain hash table: a table model predicts every result.
`default_nettype none
module sorted_chain_hash_table_test;
  import schash_pkg::*;

  localparam int unsigned NIL = PoolNodesDef;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  schash_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  schash_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgW-1:0] cfg_data = '0;

  sorted_chain_hash_table u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // table model
  int unsigned tbl_buckets;
  int unsigned tbl_heads [MaxBucketsDef];
  logic [63:0] tbl_keys [PoolNodesDef];
  logic [63:0] tbl_pays [PoolNodesDef];
  int unsigned tbl_links [PoolNodesDef];
  int unsigned tbl_free [PoolNodesDef];
  int unsigned tbl_free_cnt;

  schash_in_t  pending_reqs [$];
  schash_out_t expected_results [$];
  logic [CfgW-1:0] cfg_words [$];
  int unsigned cycle_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  int errors = 0;

  task automatic tbl_reset();
    tbl_buckets = MaxBucketsDef;
    for (int i = 0; i < MaxBucketsDef; i++) tbl_heads[i] = NIL;
    for (int i = 0; i < PoolNodesDef; i++) begin
      tbl_links[i] = NIL;
      tbl_free[i] = PoolNodesDef - 1 - i;
    end
    tbl_free_cnt = PoolNodesDef;
  endtask

  task automatic tbl_write_count(input logic [CfgW-1:0] v);
    int unsigned c;
    c = 32'(v);
    if (c == 0) c = 1;
    if (c > MaxBucketsDef) c = MaxBucketsDef;
    tbl_buckets = c;
  endtask

  function automatic schash_out_t tbl_apply(input schash_in_t r);
    schash_out_t res;
    int unsigned b, prev, cur, steps, n;
    bit found;
    res = '0;
    b = 32'(r.req_id % 64'(tbl_buckets));
    prev = NIL;
    steps = 0;
    found = 0;
    cur = tbl_heads[b];
    while (cur != NIL && steps < PoolNodesDef) begin
      if (tbl_keys[cur] == r.req_id) begin
        found = 1;
        break;
      end
      if (tbl_keys[cur] > r.req_id) break;
      prev = cur;
      cur = tbl_links[cur];
      steps++;
    end
    if (!found && steps >= PoolNodesDef) cur = NIL;
    if (r.op == OP_INSERT) begin
      if (found) begin
        res.status = ST_EXISTS;
        res.payload_out = tbl_pays[cur];
      end else if (tbl_free_cnt == 0) begin
        res.status = ST_FULL;
      end else begin
        tbl_free_cnt--;
        n = tbl_free[tbl_free_cnt];
        tbl_keys[n] = r.req_id;
        tbl_pays[n] = r.payload;
        tbl_links[n] = cur;
        if (prev == NIL) tbl_heads[b] = n;
        else tbl_links[prev] = n;
        res.status = ST_INSERTED;
      end
    end else if (!found) begin
      res.status = ST_NOT_FOUND;
    end else begin
      if (prev == NIL) tbl_heads[b] = tbl_links[cur];
      else tbl_links[prev] = tbl_links[cur];
      res.status = ST_REMOVED;
      res.payload_out = tbl_pays[cur];
      tbl_free[tbl_free_cnt] = cur;
      tbl_free_cnt++;
    end
    return res;
  endfunction

  function automatic bit quiet_window();
    return (cycle_cnt % 30000) < 6000;
  endfunction

  function automatic bit roll_idle();
    return !quiet_window() && ($urandom_range(99) < 11);
  endfunction

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_results.push_back(tbl_apply(in_data));
      if (pending_reqs.size() != 0 && !roll_idle()) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // register writer
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      tbl_write_count(cfg_data);
      cfg_valid <= 1'b0;
    end else if (!cfg_valid && cfg_words.size() != 0) begin
      cfg_valid <= 1'b1;
      cfg_data <= cfg_words.pop_front();
    end
  end

  // hold off once for a long stretch to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (out_valid && out_ready && results_seen == 60) begin
      hold_left <= 3000;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor with receiver stalls
  always @(posedge clk) begin
    schash_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0d payload=%h", $time,
                   out_data.status, out_data.payload_out);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status != want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_data.status);
          end
          if (out_data.payload_out != want.payload_out) begin
            errors++;
            $display("%0t: payload expected %h actual %h", $time,
                     want.payload_out, out_data.payload_out);
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= !roll_idle();
      end
    end
  end

  task automatic push_req(input logic op, input logic [63:0] id, input logic [63:0] pay);
    schash_in_t r;
    r.op = op;
    r.req_id = id;
    r.payload = pay;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_count(input logic [CfgW-1:0] v);
    wait_drained();
    repeat (200) @(posedge clk);
    cfg_words.push_back(v);
    while (cfg_words.size() != 0 || cfg_valid) @(posedge clk);
  endtask

  // mixed inserts and removes over a small key set so hits are common
  task automatic mixed_ops(input int n);
    logic [63:0] keys [26];
    logic op;
    for (int i = 0; i < 24; i++) keys[i] = rand64();
    keys[24] = '0;
    keys[25] = '1;
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(1) ? OP_REMOVE : OP_INSERT;
      if ($urandom_range(9) == 0) push_req(op, rand64(), rand64());
      else push_req(op, keys[$urandom_range(25)], rand64());
    end
  endtask

  initial begin
    logic [63:0] filled [$];
    int unsigned nfree;
    tbl_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, sorted placement, every status but full
    push_req(OP_INSERT, 64'd0, 64'd0);
    push_req(OP_INSERT, '1, '1);
    push_req(OP_INSERT, 64'd0, 64'h1234);
    push_req(OP_INSERT, 64'd517, 64'hA5A5_5A5A_0F0F_F0F0);
    push_req(OP_INSERT, 64'd5, 64'h1);
    push_req(OP_INSERT, 64'd261, 64'h2);
    push_req(OP_INSERT, 64'd773, 64'h3);
    push_req(OP_INSERT, 64'd261, 64'h9);
    push_req(OP_REMOVE, 64'd261, 64'h0);
    push_req(OP_REMOVE, 64'd261, 64'h0);
    push_req(OP_REMOVE, 64'd5, '1);
    push_req(OP_REMOVE, 64'd773, 64'h0);
    push_req(OP_INSERT, 64'd261, 64'h4);
    push_req(OP_REMOVE, '1, 64'h0);
    push_req(OP_REMOVE, '1, 64'h0);
    push_req(OP_REMOVE, 64'd0, 64'h0);
    push_req(OP_REMOVE, 64'h8000_0000_0000_0000, '1);

    // zero bucket count falls back to a single bucket; old chains stay put
    write_count('0);
    mixed_ops(50);
    write_count(9'd3);
    mixed_ops(50);

    // fill the pool to the brim, then overflow it
    write_count('1);
    wait_drained();
    nfree = tbl_free_cnt;
    for (int i = 0; i < nfree; i++) begin
      filled.push_back(rand64());
      push_req(OP_INSERT, filled[i], rand64());
    end
    for (int i = 0; i < 6; i++) push_req(OP_INSERT, rand64(), rand64());
    push_req(OP_INSERT, filled[0], rand64());
    push_req(OP_INSERT, filled[nfree-1], rand64());
    for (int i = 0; i < 100; i++)
      push_req(OP_REMOVE, filled[$urandom_range(nfree-1)], rand64());

    write_count(9'd300);
    mixed_ops(40);
    write_count(9'd1);
    mixed_ops(20);

    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
